// File: rtl/baep_pkg.sv
package baep_pkg;

  // field widths
  localparam int COORD_BITS = 20;
  localparam int FRAC_BITS  = 16;
  localparam int TOL_BITS   = 20;
  localparam int ROOT_W     = 7;
  localparam int COUNT_W    = 2;

  // derived datapath widths
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int E_W    = COORD_BITS + 2;
  localparam int DEN_W  = COORD_BITS + 3;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int D_W    = PROD_W;
  localparam int DS_W   = PROD_W + 1;
  localparam int RAD_W  = D_W + 2 * FRAC_BITS;
  localparam int SQ_W   = RAD_W / 2;
  localparam int REM_W  = SQ_W + 3;
  localparam int DN_W   = DEN_W + FRAC_BITS;
  localparam int NUM_W  = DN_W + 1;
  localparam int DVS_W  = DN_W + 1;
  localparam int NQ_W   = DN_W + 9;
  localparam int QW     = ROOT_W;

  // scale of the hundredths output, doubled for half-away rounding
  localparam int PCT        = 100;
  localparam int ROUND_SCALE = 2 * PCT;

  localparam logic AXIS_Y = 1'b1;

  typedef struct packed {
    logic                         axis_select;
    logic signed [COORD_BITS-1:0] p0_x;
    logic signed [COORD_BITS-1:0] p0_y;
    logic signed [COORD_BITS-1:0] p1_x;
    logic signed [COORD_BITS-1:0] p1_y;
    logic signed [COORD_BITS-1:0] p2_x;
    logic signed [COORD_BITS-1:0] p2_y;
    logic signed [COORD_BITS-1:0] p3_x;
    logic signed [COORD_BITS-1:0] p3_y;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] root_count;
    logic [ROOT_W-1:0]  first_root;
    logic [ROOT_W-1:0]  second_root;
  } result_t;

  // sideband carried alongside the square root pipeline
  typedef struct packed {
    logic                     lin;
    logic                     c1;
    logic                     c2;
    logic signed [DIFF_W-1:0] a;
    logic signed [E_W-1:0]    e;
    logic signed [DEN_W-1:0]  den;
  } sq_side_t;

  // sideband carried alongside the divider pipeline
  typedef struct packed {
    logic keep1;
    logic keep2;
  } div_side_t;

endpackage

// File: rtl/baep_sqrt.sv
module baep_sqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [baep_pkg::D_W-1:0] in_rad,
  input  baep_pkg::sq_side_t       in_side,
  output logic                     out_valid,
  output logic [baep_pkg::SQ_W-1:0] out_root,
  output baep_pkg::sq_side_t       out_side
);
  import baep_pkg::*;

  // stage k register holds the state after result bit k
  logic             vld  [SQ_W];
  logic [REM_W-1:0] rem  [SQ_W];
  logic [SQ_W-1:0]  root [SQ_W];
  logic [RAD_W-1:0] rad  [SQ_W];
  sq_side_t         side [SQ_W];

  logic             src_v    [SQ_W];
  logic [REM_W-1:0] src_rem  [SQ_W];
  logic [SQ_W-1:0]  src_root [SQ_W];
  logic [RAD_W-1:0] src_rad  [SQ_W];
  sq_side_t         src_side [SQ_W];

  logic [REM_W-1:0] nxt_rem  [SQ_W];
  logic [SQ_W-1:0]  nxt_root [SQ_W];

  // one result bit per stage, two radicand bits shifted in
  always_comb begin
    logic [REM_W-1:0] tr_rem;
    logic [REM_W-1:0] tr;
    src_v[0]    = in_valid;
    src_rem[0]  = '0;
    src_root[0] = '0;
    src_rad[0]  = {in_rad, {(2 * FRAC_BITS){1'b0}}};
    src_side[0] = in_side;
    for (int k = 1; k < SQ_W; k++) begin
      src_v[k]    = vld[k-1];
      src_rem[k]  = rem[k-1];
      src_root[k] = root[k-1];
      src_rad[k]  = rad[k-1];
      src_side[k] = side[k-1];
    end
    for (int k = 0; k < SQ_W; k++) begin
      tr_rem = {src_rem[k][REM_W-3:0], src_rad[k][RAD_W-1 -: 2]};
      tr     = {{(REM_W - SQ_W - 2){1'b0}}, src_root[k], 2'b01};
      if (tr_rem >= tr) begin
        nxt_rem[k]  = tr_rem - tr;
        nxt_root[k] = {src_root[k][SQ_W-2:0], 1'b1};
      end else begin
        nxt_rem[k]  = tr_rem;
        nxt_root[k] = {src_root[k][SQ_W-2:0], 1'b0};
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SQ_W; k++) vld[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < SQ_W; k++) vld[k] <= src_v[k];
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQ_W; k++) begin
        rem[k]  <= nxt_rem[k];
        root[k] <= nxt_root[k];
        rad[k]  <= src_rad[k] << 2;
        side[k] <= src_side[k];
      end
    end
  end

  assign out_valid = vld[SQ_W-1];
  assign out_root  = root[SQ_W-1];
  assign out_side  = side[SQ_W-1];

endmodule

// File: rtl/baep_div.sv
module baep_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [baep_pkg::DVS_W-1:0] in_dvs,
  input  logic [baep_pkg::NQ_W-1:0]  in_n1,
  input  logic [baep_pkg::NQ_W-1:0]  in_n2,
  input  baep_pkg::div_side_t        in_side,
  output logic                       out_valid,
  output logic [baep_pkg::QW-1:0]    out_q1,
  output logic [baep_pkg::QW-1:0]    out_q2,
  output baep_pkg::div_side_t        out_side
);
  import baep_pkg::*;

  logic             vld  [QW];
  logic [NQ_W-1:0]  rem1 [QW];
  logic [NQ_W-1:0]  rem2 [QW];
  logic [QW-1:0]    q1   [QW];
  logic [QW-1:0]    q2   [QW];
  logic [DVS_W-1:0] dvs  [QW];
  div_side_t        side [QW];

  logic             src_v    [QW];
  logic [NQ_W-1:0]  src_rem1 [QW];
  logic [NQ_W-1:0]  src_rem2 [QW];
  logic [QW-1:0]    src_q1   [QW];
  logic [QW-1:0]    src_q2   [QW];
  logic [DVS_W-1:0] src_dvs  [QW];
  div_side_t        src_side [QW];

  logic [NQ_W-1:0]  nxt_rem1 [QW];
  logic [NQ_W-1:0]  nxt_rem2 [QW];
  logic [QW-1:0]    nxt_q1   [QW];
  logic [QW-1:0]    nxt_q2   [QW];

  // restoring division, one quotient bit per stage, both candidates share the divisor
  always_comb begin
    logic [NQ_W-1:0] sub;
    src_v[0]    = in_valid;
    src_rem1[0] = in_n1;
    src_rem2[0] = in_n2;
    src_q1[0]   = '0;
    src_q2[0]   = '0;
    src_dvs[0]  = in_dvs;
    src_side[0] = in_side;
    for (int k = 1; k < QW; k++) begin
      src_v[k]    = vld[k-1];
      src_rem1[k] = rem1[k-1];
      src_rem2[k] = rem2[k-1];
      src_q1[k]   = q1[k-1];
      src_q2[k]   = q2[k-1];
      src_dvs[k]  = dvs[k-1];
      src_side[k] = side[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      sub = {{(NQ_W - DVS_W){1'b0}}, src_dvs[k]} << (QW - 1 - k);
      if (src_rem1[k] >= sub) begin
        nxt_rem1[k] = src_rem1[k] - sub;
        nxt_q1[k]   = {src_q1[k][QW-2:0], 1'b1};
      end else begin
        nxt_rem1[k] = src_rem1[k];
        nxt_q1[k]   = {src_q1[k][QW-2:0], 1'b0};
      end
      if (src_rem2[k] >= sub) begin
        nxt_rem2[k] = src_rem2[k] - sub;
        nxt_q2[k]   = {src_q2[k][QW-2:0], 1'b1};
      end else begin
        nxt_rem2[k] = src_rem2[k];
        nxt_q2[k]   = {src_q2[k][QW-2:0], 1'b0};
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QW; k++) vld[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < QW; k++) vld[k] <= src_v[k];
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem1[k] <= nxt_rem1[k];
        rem2[k] <= nxt_rem2[k];
        q1[k]   <= nxt_q1[k];
        q2[k]   <= nxt_q2[k];
        dvs[k]  <= src_dvs[k];
        side[k] <= src_side[k];
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign out_q1    = q1[QW-1];
  assign out_q2    = q2[QW-1];
  assign out_side  = side[QW-1];

endmodule

// File: rtl/bezier_axis_extremum_params_unit.sv
// throughput: one item per cycle; the whole pipeline advances together and
//   holds while the output register is full and not taken
// the depth is set mostly by the fixed-point square root, one bit per stage
// reset clears all valid bits and sets zero_tolerance to 0
module bezier_axis_extremum_params_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  baep_pkg::item_t               item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output baep_pkg::result_t             result,
  input  logic                          tol_we,
  input  logic [baep_pkg::TOL_BITS-1:0] tol_data
);
  import baep_pkg::*;

  // tolerance register
  logic [TOL_BITS-1:0] zero_tolerance;
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_tolerance <= '0;
    end else if (tol_we) begin
      zero_tolerance <= tol_data;
    end
  end

  // pipeline advance
  logic en;
  assign en         = !result_valid || result_ready;
  assign item_ready = en;

  // axis select
  logic signed [COORD_BITS-1:0] q0, q1, q2, q3;
  always_comb begin
    if (item.axis_select == AXIS_Y) begin
      q0 = item.p0_y; q1 = item.p1_y; q2 = item.p2_y; q3 = item.p3_y;
    end else begin
      q0 = item.p0_x; q1 = item.p1_x; q2 = item.p2_x; q3 = item.p3_x;
    end
  end

  // stage 1: control point differences
  logic                     v1;
  logic signed [DIFF_W-1:0] a1, b1, c1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= item_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= $signed({q1[COORD_BITS-1], q1}) - $signed({q0[COORD_BITS-1], q0});
      b1 <= $signed({q2[COORD_BITS-1], q2}) - $signed({q1[COORD_BITS-1], q1});
      c1 <= $signed({q3[COORD_BITS-1], q3}) - $signed({q2[COORD_BITS-1], q2});
    end
  end

  // stage 2: quadratic coefficients and products
  logic signed [DEN_W-1:0]  ax, bx, cx, ex;
  assign ax = $signed({{(DEN_W - DIFF_W){a1[DIFF_W-1]}}, a1});
  assign bx = $signed({{(DEN_W - DIFF_W){b1[DIFF_W-1]}}, b1});
  assign cx = $signed({{(DEN_W - DIFF_W){c1[DIFF_W-1]}}, c1});
  assign ex = ax - bx;

  logic                     v2;
  logic signed [DIFF_W-1:0] a2;
  logic signed [E_W-1:0]    e2;
  logic signed [DEN_W-1:0]  den2;
  logic signed [PROD_W-1:0] bb2, ac2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a2   <= a1;
      e2   <= ex[E_W-1:0];
      den2 <= ax - (bx <<< 1) + cx;
      bb2  <= b1 * b1;
      ac2  <= a1 * c1;
    end
  end

  // stage 3: discriminant and tolerance tests on the coefficients
  logic [DEN_W-1:0] den_mag;
  logic [E_W-1:0]   e_mag;
  assign den_mag = den2[DEN_W-1] ? (~den2 + 1'b1) : den2;
  assign e_mag   = e2[E_W-1] ? (~e2 + 1'b1) : e2;

  logic                     v3, lin3, elarge3;
  logic signed [DIFF_W-1:0] a3;
  logic signed [E_W-1:0]    e3;
  logic signed [DEN_W-1:0]  den3;
  logic signed [DS_W-1:0]   ds3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a3      <= a2;
      e3      <= e2;
      den3    <= den2;
      ds3     <= $signed({bb2[PROD_W-1], bb2}) - $signed({ac2[PROD_W-1], ac2});
      lin3    <= ({2'b00, den_mag} + {1'b0, den_mag, 1'b0})
                 <= {{(DEN_W + 2 - TOL_BITS){1'b0}}, zero_tolerance};
      elarge3 <= ({2'b00, e_mag} + {1'b0, e_mag, 1'b0})
                 > {{(E_W + 2 - TOL_BITS){1'b0}}, zero_tolerance};
    end
  end

  // candidate selection into the square root
  logic [D_W-1:0]   dmag;
  logic [D_W+3:0]   d9;
  logic             dneg, dbig;
  sq_side_t         sq_in;
  assign dneg = ds3[DS_W-1];
  assign dmag = ds3[D_W-1:0];
  assign d9   = {4'b0000, dmag} + {1'b0, dmag, 3'b000};
  assign dbig = d9 > {{(D_W + 4 - TOL_BITS){1'b0}}, zero_tolerance};

  always_comb begin
    sq_in.lin = lin3;
    sq_in.c1  = lin3 ? elarge3 : !dneg;
    sq_in.c2  = !lin3 && !dneg && dbig;
    sq_in.a   = a3;
    sq_in.e   = e3;
    sq_in.den = den3;
  end

  logic            vs;
  logic [SQ_W-1:0] sroot;
  sq_side_t        sq_out;

  baep_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .in_rad    (dmag),
    .in_side   (sq_in),
    .out_valid (vs),
    .out_root  (sroot),
    .out_side  (sq_out)
  );

  // candidate numerators, sign fix and range check
  logic signed [NUM_W-1:0] n1, n2, dns;
  logic                    keep1, keep2;
  always_comb begin
    logic signed [NUM_W-1:0] base;
    logic signed [NUM_W-1:0] sx;
    base = $signed({{(NUM_W - E_W){sq_out.e[E_W-1]}}, sq_out.e}) <<< FRAC_BITS;
    sx   = $signed({{(NUM_W - SQ_W){1'b0}}, sroot});
    if (sq_out.lin) begin
      n1  = $signed({{(NUM_W - DIFF_W){sq_out.a[DIFF_W-1]}}, sq_out.a});
      n2  = n1;
      dns = $signed({{(NUM_W - E_W){sq_out.e[E_W-1]}}, sq_out.e}) <<< 1;
    end else begin
      n1  = base - sx;
      n2  = base + sx;
      dns = $signed({{(NUM_W - DEN_W){sq_out.den[DEN_W-1]}}, sq_out.den}) <<< FRAC_BITS;
    end
    if (dns[NUM_W-1]) begin
      n1  = -n1;
      n2  = -n2;
      dns = -dns;
    end
    keep1 = sq_out.c1 && !n1[NUM_W-1] && (n1 <= dns);
    keep2 = sq_out.c2 && !n2[NUM_W-1] && (n2 <= dns);
  end

  logic            vp, kp1, kp2;
  logic [DN_W-1:0] np1, np2, dnp;
  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (en) begin
      vp <= vs;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      kp1 <= keep1;
      kp2 <= keep2;
      np1 <= n1[DN_W-1:0];
      np2 <= n2[DN_W-1:0];
      dnp <= dns[DN_W-1:0];
    end
  end

  // rounding numerators: 200*num + den over 2*den
  logic             vm;
  logic [NQ_W-1:0]  nm1, nm2;
  logic [DVS_W-1:0] dvm;
  div_side_t        dm_side;
  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= vp;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      nm1           <= {{(NQ_W - DN_W){1'b0}}, np1} * NQ_W'(ROUND_SCALE)
                       + {{(NQ_W - DN_W){1'b0}}, dnp};
      nm2           <= {{(NQ_W - DN_W){1'b0}}, np2} * NQ_W'(ROUND_SCALE)
                       + {{(NQ_W - DN_W){1'b0}}, dnp};
      dvm           <= {dnp, 1'b0};
      dm_side.keep1 <= kp1;
      dm_side.keep2 <= kp2;
    end
  end

  logic          vq;
  logic [QW-1:0] hq1, hq2;
  div_side_t     dq_side;

  baep_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vm),
    .in_dvs    (dvm),
    .in_n1     (nm1),
    .in_n2     (nm2),
    .in_side   (dm_side),
    .out_valid (vq),
    .out_q1    (hq1),
    .out_q2    (hq2),
    .out_side  (dq_side)
  );

  // output register: kept roots in order
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= vq;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      result.root_count  <= COUNT_W'(dq_side.keep1) + COUNT_W'(dq_side.keep2);
      result.first_root  <= dq_side.keep1 ? hq1 : (dq_side.keep2 ? hq2 : '0);
      result.second_root <= (dq_side.keep1 && dq_side.keep2) ? hq2 : '0;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.root_count != COUNT_W'(3))
    else $error("root count out of range");

  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.root_count == '0 |-> result.first_root == '0)
    else $error("first root set with no roots");

  a_second_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.root_count != COUNT_W'(2) |-> result.second_root == '0)
    else $error("second root set with fewer than two roots");

  a_root_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.first_root <= ROOT_W'(PCT) && result.second_root <= ROOT_W'(PCT))
    else $error("root above one");
`endif

endmodule

// File: test/bezier_axis_extremum_params_checker.sv
module bezier_axis_extremum_params_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_ready,
  input  baep_pkg::item_t               item,
  input  logic                          result_valid,
  input  logic                          result_ready,
  input  baep_pkg::result_t             result,
  input  logic                          tol_we,
  input  logic [baep_pkg::TOL_BITS-1:0] tol_data,
  output int                            fail_count,
  output int                            pending,
  output int                            checked
);
  import baep_pkg::*;

  logic [TOL_BITS-1:0] tolerance;
  result_t             expected_roots[$];

  // hundredths of num/(den*2^F) when within [0,1], rounded half away from zero
  function automatic logic scale_candidate(input logic signed [127:0] num,
                                           input logic signed [127:0] den,
                                           output logic [6:0] hund);
    logic signed [127:0] n, dn;
    n = num;
    dn = den <<< FRAC_BITS;
    hund = '0;
    if (dn < 0) begin
      n = -n;
      dn = -dn;
    end
    if (n < 0 || n > dn) return 1'b0;
    hund = 7'((200 * n + dn) / (2 * dn));
    return 1'b1;
  endfunction

  // integer floor square root
  function automatic logic [127:0] isqrt(input logic [127:0] v);
    logic [127:0] r, cand;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = r | (128'd1 << b);
      if (cand * cand <= v) r = cand;
    end
    return r;
  endfunction

  function automatic result_t axis_extrema(input item_t it, input logic [TOL_BITS-1:0] tol);
    logic signed [127:0] q0, q1, q2, q3, a, b, c, e, den, d, s, base, an, en, t3;
    logic [6:0] h;
    logic [6:0] roots[2];
    int n;
    result_t r;
    if (it.axis_select == AXIS_Y) begin
      q0 = it.p0_y; q1 = it.p1_y; q2 = it.p2_y; q3 = it.p3_y;
    end else begin
      q0 = it.p0_x; q1 = it.p1_x; q2 = it.p2_x; q3 = it.p3_x;
    end
    a = q1 - q0; b = q2 - q1; c = q3 - q2;
    e = a - b; den = a - 2 * b + c;
    roots[0] = '0; roots[1] = '0; n = 0;
    t3 = (den < 0) ? -3 * den : 3 * den;
    if (t3 <= tol) begin
      // linear case, or flat with no root
      if (((e < 0) ? -3 * e : 3 * e) > tol) begin
        an = a; en = e;
        if (en < 0) begin
          an = -an;
          en = -en;
        end
        if (an >= 0 && an <= 2 * en) begin
          roots[n] = 7'((100 * an + en) / (2 * en));
          n++;
        end
      end
    end else begin
      d = b * b - a * c;
      if (d >= 0) begin
        s = isqrt(d << (2 * FRAC_BITS));
        base = e <<< FRAC_BITS;
        if (scale_candidate(base - s, den, h)) begin
          roots[n] = h;
          n++;
        end
        // double root keeps only the first candidate
        if (d > tol / 9) begin
          if (scale_candidate(base + s, den, h)) begin
            roots[n] = h;
            n++;
          end
        end
      end
    end
    r.root_count = COUNT_W'(n);
    r.first_root = roots[0];
    r.second_root = roots[1];
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      tolerance <= '0;
      expected_roots.delete();
      fail_count <= 0;
      checked <= 0;
      pending <= 0;
    end else begin
      if (tol_we) tolerance <= tol_data;
      if (item_valid && item_ready) begin
        expected_roots = {expected_roots, axis_extrema(item, tolerance)};
      end
      if (result_valid && result_ready) begin
        checked <= checked + 1;
        if (expected_roots.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", result);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_roots.pop_front();
          if (want !== result) begin
            if (fail_count < 10)
              $display("mismatch: expected count %0d roots %0d %0d, got %0d %0d %0d",
                       want.root_count, want.first_root, want.second_root,
                       result.root_count, result.first_root, result.second_root);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_roots.size();
    end
  end
endmodule

// File: test/bezier_axis_extremum_params_unit_tb.sv
module bezier_axis_extremum_params_unit_tb;
  import baep_pkg::*;

  localparam int LATENCY = 50;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_ready;
  item_t               item = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  result_t             result;
  logic                tol_we = 1'b0;
  logic [TOL_BITS-1:0] tol_data = '0;
  int                  fail_count, pending, checked;
  int                  sent = 0;
  logic                hold_off = 1'b0;
  logic                calm = 1'b0;

  always #5 clk = ~clk;

  bezier_axis_extremum_params_unit u_dut (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .tol_we(tol_we), .tol_data(tol_data)
  );

  bezier_axis_extremum_params_checker u_check (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .tol_we(tol_we), .tol_data(tol_data),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? -20'sd524288 : 20'sd524287;
      1: return COORD_BITS'($signed($urandom_range(0, 64)) - 32);
      2: return COORD_BITS'($signed($urandom_range(0, 4000)) - 2000);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  // control points on one axis; other axis random
  function automatic item_t make_curve(input logic sel, input int q0, input int q1,
                                       input int q2, input int q3);
    item_t it;
    it.axis_select = sel;
    it.p0_x = rand_coord(); it.p1_x = rand_coord();
    it.p2_x = rand_coord(); it.p3_x = rand_coord();
    it.p0_y = rand_coord(); it.p1_y = rand_coord();
    it.p2_y = rand_coord(); it.p3_y = rand_coord();
    if (sel == AXIS_Y) begin
      it.p0_y = COORD_BITS'(q0); it.p1_y = COORD_BITS'(q1);
      it.p2_y = COORD_BITS'(q2); it.p3_y = COORD_BITS'(q3);
    end else begin
      it.p0_x = COORD_BITS'(q0); it.p1_x = COORD_BITS'(q1);
      it.p2_x = COORD_BITS'(q2); it.p3_x = COORD_BITS'(q3);
    end
    return it;
  endfunction

  // valid stays up after an accept unless an idle cycle follows
  task automatic send_curve(input item_t it);
    while (!calm && $urandom_range(0, 99) < 25) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    sent++;
  endtask

  // wait until the pipe is empty, then write the tolerance
  task automatic set_tolerance(input logic [TOL_BITS-1:0] v);
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    tol_we <= 1'b1;
    tol_data <= v;
    @(posedge clk);
    tol_we <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    int q0, q1, q2, q3;
    for (int i = 0; i < count; i++) begin
      q0 = rand_coord(); q1 = rand_coord(); q2 = rand_coord(); q3 = rand_coord();
      // a quarter small curves, so roots land in [0,1] and near-degenerate cases appear
      case ($urandom_range(0, 3))
        0: begin q1 = q0 + $signed($urandom_range(0, 200)) - 100;
                 q2 = q1 + $signed($urandom_range(0, 200)) - 100;
                 q3 = q2 - q1 + q2 + $signed($urandom_range(0, 6)) - 3; end
        1: begin q3 = q0 + $signed($urandom_range(0, 40)) - 20;
                 q2 = q1 + $signed($urandom_range(0, 40)) - 20; end
        default: ;
      endcase
      send_curve(make_curve(1'($urandom_range(0, 1)), q0, q1, q2, q3));
    end
  endtask

  // receiver: random stalls, plus one long hold-off
  always @(posedge clk) begin
    if (rst) result_ready <= 1'b0;
    else result_ready <= !hold_off && (calm || $urandom_range(0, 99) >= 25);
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: linear, flat, double root, two roots, extremes
    send_curve(make_curve(0, 0, 0, 0, 0));
    send_curve(make_curve(1, 0, 10, 10, 0));
    send_curve(make_curve(0, 0, 30, -30, 0));
    send_curve(make_curve(1, 0, 10, 20, 30));
    send_curve(make_curve(0, 0, 10, 0, 10));
    send_curve(make_curve(1, 0, 100, 100, 100));
    send_curve(make_curve(0, 0, 2, 3, 3));
    send_curve(make_curve(1, 0, 1, 0, 1));
    send_curve(make_curve(0, -524288, 524287, -524288, 524287));
    send_curve(make_curve(1, 524287, -524288, 524287, -524288));
    send_curve(make_curve(0, -524288, -524288, 524287, 524287));
    send_curve(make_curve(1, 524287, 524287, 524287, -524288));
    send_curve(make_curve(0, 0, 100, -50, 0));
    send_curve(make_curve(1, 5, 5, 5, 6));
    set_tolerance(20'd30);
    send_curve(make_curve(0, 0, 10, 10, 0));
    send_curve(make_curve(1, 0, 1, 2, 3));
    send_curve(make_curve(0, 0, 5, 1, 0));
    set_tolerance(20'hFFFFF);
    send_curve(make_curve(1, 0, 10, 10, 0));
    send_curve(make_curve(0, -524288, 524287, -524288, 524287));
    set_tolerance(20'd0);

    random_phase(150);
    set_tolerance(20'd9);
    // long hold-off with the sender still pushing
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      random_phase(150);
    join
    set_tolerance(20'd1000);
    calm = 1'b1;
    random_phase(150);
    calm = 1'b0;
    set_tolerance(20'hFFFFF);
    random_phase(60);
    set_tolerance(20'd3);
    random_phase(90);

    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d curves over six tolerance settings, %0d results checked",
             sent, checked);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end
endmodule
